// ----- rtl/core/gasp_pkg.sv -----
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types and constants of the glyph atlas skyline packer: register
// map, reset values and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int ARITH_W = 18;
  localparam int ADDR_W  = 4;

  localparam logic [1:0] REG_PAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SPACING     = 2'd2;

  localparam logic [12:0] PAGE_WIDTH_RESET  = 13'd1024;
  localparam logic [12:0] PAGE_HEIGHT_RESET = 13'd1024;
  localparam logic [7:0]  SPACING_RESET     = 8'd1;

  typedef struct packed {
    logic accept;
    logic check;
    logic scan_start;
    logic scan_step;
    logic place;
    logic emit;
  } gasp_cmd_t;

  typedef struct packed {
    logic oversize;
    logic scan_direct;
    logic scan_done;
    logic out_free;
  } gasp_sts_t;

endpackage

// ----- rtl/core/gasp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gasp_ctrl
// Sequencer of the packer: takes an item, runs the fit check, walks the
// reference skyline one segment a cycle, places the glyph and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module gasp_ctrl import gasp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gasp_sts_t sts,
  output gasp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.oversize ? S_EMIT : S_START;
      end
      S_START: begin
        cmd.scan_start = 1'b1;
        state_next     = sts.scan_direct ? S_PLACE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/gasp_dp.sv -----
// ----------------------------------------------------------------------------
// gasp_dp
// Datapath of the packer: cursor, page counter, the two segment banks in
// one memory, the skyline maximum search and the output register.
// ----------------------------------------------------------------------------
module gasp_dp import gasp_pkg::*; #(
  parameter int MAX_SEGMENTS = 256,
  parameter int COORD_BITS   = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  gasp_cmd_t   cmd,
  output gasp_sts_t   sts,
  input  logic [12:0] page_width,
  input  logic [12:0] page_height,
  input  logic [7:0]  spacing,
  input  logic        cfg_init,
  input  logic [11:0] glyph_width,
  input  logic [11:0] glyph_height,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        placed,
  output logic [15:0] page_index,
  output logic [12:0] x_pos,
  output logic [12:0] y_pos,
  output logic        opened_page,
  output logic        segment_overflow
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W = 3 * COORD_BITS;
  localparam int DEPTH = 2 ** (IDX_W + 1);
  localparam logic [ARITH_W-1:0] COORD_MASK = (ARITH_W'(1) << COORD_BITS) - ARITH_W'(1);
  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(MAX_SEGMENTS);

  logic [SEG_W-1:0] mem [DEPTH];
  logic [SEG_W-1:0] rd_data;

  logic [11:0]           w_reg;
  logic [11:0]           h_reg;
  logic [COORD_BITS-1:0] cursor_x;
  logic [15:0]           page_count;
  logic                  bank_select;
  logic                  fresh;
  logic [CNT_W-1:0]      reference_count;
  logic [CNT_W-1:0]      current_count;
  logic [CNT_W-1:0]      scan_idx;
  logic [ARITH_W-1:0]    lo;
  logic [ARITH_W-1:0]    hi;
  logic [ARITH_W-1:0]    top;
  logic                  entered;

  logic                  res_placed;
  logic [15:0]           res_page;
  logic [12:0]           res_x;
  logic [12:0]           res_y;
  logic                  res_opened;
  logic                  res_ovf;

  logic [ARITH_W-1:0] w_ext;
  logic [ARITH_W-1:0] h_ext;
  logic [ARITH_W-1:0] sp_ext;
  logic [ARITH_W-1:0] pw_ext;
  logic [ARITH_W-1:0] ph_ext;
  logic [ARITH_W-1:0] right_try;
  logic               wrap;
  logic [ARITH_W-1:0] left_new;
  logic [ARITH_W-1:0] right_new;

  logic [ARITH_W-1:0] seg_start;
  logic [ARITH_W-1:0] seg_end;
  logic [ARITH_W-1:0] seg_y;
  logic               hit_lo;
  logic               hit_hi;
  logic               entered_next;

  logic [ARITH_W-1:0] bottom_try;
  logic               new_page;
  logic [ARITH_W-1:0] top_fin;
  logic [ARITH_W-1:0] bottom_fin;
  logic [CNT_W-1:0]   cur_eff;
  logic               ovf;
  logic [15:0]        page_inc;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W:0]   rd_addr;
  logic [IDX_W:0]   wr_addr;

  assign w_ext  = ARITH_W'(w_reg);
  assign h_ext  = ARITH_W'(h_reg);
  assign sp_ext = ARITH_W'(spacing);
  assign pw_ext = ARITH_W'(page_width);
  assign ph_ext = ARITH_W'(page_height);

  assign right_try = ARITH_W'(cursor_x) + w_ext + sp_ext;
  assign wrap      = (right_try > pw_ext);
  assign left_new  = wrap ? sp_ext : ARITH_W'(cursor_x);
  assign right_new = left_new + w_ext + sp_ext;

  assign seg_start    = ARITH_W'(rd_data[SEG_W-1 -: COORD_BITS]);
  assign seg_end      = ARITH_W'(rd_data[2*COORD_BITS-1 -: COORD_BITS]);
  assign seg_y        = ARITH_W'(rd_data[COORD_BITS-1:0]);
  assign hit_lo       = (lo >= seg_start) && (lo <= seg_end);
  assign hit_hi       = (hi >= seg_start) && (hi <= seg_end);
  assign entered_next = entered || hit_lo;

  assign bottom_try = top + h_ext + sp_ext;
  assign new_page   = (bottom_try > ph_ext);
  assign top_fin    = new_page ? (sp_ext & COORD_MASK) : top;
  assign bottom_fin = top_fin + h_ext + sp_ext;
  assign cur_eff    = new_page ? '0 : current_count;
  assign ovf        = (cur_eff == CNT_MAX);
  assign page_inc   = (page_count == 16'hFFFF) ? page_count : page_count + 16'd1;

  assign rd_idx  = cmd.scan_start ? '0 : scan_idx[IDX_W-1:0];
  assign rd_addr = {~bank_select, rd_idx};
  assign wr_addr = {bank_select, cur_eff[IDX_W-1:0]};

  assign sts.oversize    = (w_ext + {sp_ext[ARITH_W-2:0], 1'b0} > pw_ext) ||
                           (h_ext + {sp_ext[ARITH_W-2:0], 1'b0} > ph_ext);
  assign sts.scan_direct = fresh || (reference_count == '0);
  assign sts.scan_done   = hit_hi || (scan_idx == reference_count);
  assign sts.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (cmd.place && !ovf) begin
      mem[wr_addr] <= {lo[COORD_BITS-1:0], hi[COORD_BITS-1:0], bottom_fin[COORD_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      w_reg <= glyph_width;
      h_reg <= glyph_height;
    end
    if (cmd.check) begin
      lo      <= left_new;
      hi      <= right_new;
      top     <= '0;
      entered <= 1'b0;
      {res_placed, res_page, res_x, res_y, res_opened, res_ovf} <= '0;
    end
    if (cmd.scan_start) begin
      scan_idx <= CNT_W'(1);
      if (fresh && (lo <= (pw_ext & COORD_MASK))) begin
        top <= sp_ext & COORD_MASK;
      end
    end
    if (cmd.scan_step && !sts.scan_done) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (cmd.scan_step) begin
      entered <= entered_next;
      if (entered_next && (seg_y > top)) begin
        top <= seg_y;
      end
    end
    if (cmd.place) begin
      res_placed <= 1'b1;
      res_page   <= new_page ? page_inc : page_count;
      res_x      <= lo[12:0];
      res_y      <= top_fin[12:0];
      res_opened <= new_page;
      res_ovf    <= ovf;
    end
    if (cmd.emit) begin
      placed           <= res_placed;
      page_index       <= res_page;
      x_pos            <= res_x;
      y_pos            <= res_y;
      opened_page      <= res_opened;
      segment_overflow <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_init) begin
      cursor_x        <= rst ? COORD_BITS'(SPACING_RESET) : COORD_BITS'(spacing);
      page_count      <= '0;
      bank_select     <= 1'b0;
      fresh           <= 1'b1;
      reference_count <= CNT_W'(1);
      current_count   <= '0;
    end else begin
      if (cmd.check && !sts.oversize && wrap) begin
        bank_select     <= ~bank_select;
        reference_count <= current_count;
        current_count   <= '0;
        fresh           <= 1'b0;
      end
      if (cmd.place) begin
        cursor_x      <= hi[COORD_BITS-1:0];
        current_count <= ovf ? cur_eff : cur_eff + CNT_W'(1);
        if (new_page) begin
          page_count      <= page_inc;
          fresh           <= 1'b1;
          reference_count <= CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/glyph_atlas_skyline_packer.sv -----
// ----------------------------------------------------------------------------
// glyph_atlas_skyline_packer
// Places glyph rectangles on fixed-size texture pages along a skyline,
// row by row, opening a new page when a glyph passes the page bottom.
//
//   Channel  Direction  Handshake           Payload
//   in       to block   in_valid/in_ready   glyph_width, glyph_height
//   out      from block out_valid/out_ready placed, page_index, x_pos, y_pos,
//                                           opened_page, segment_overflow
//   config   to block   APB, pready high    page_width, page_height, spacing
//
// A skipped glyph goes from the fit check straight to its result; a placed
// glyph adds the scan start, a scan of up to MAX_SEGMENTS reference
// segments and the placement; the segment memory delivers one segment a
// cycle. Reset and every write to a mapped register restore the empty first
// page; a register write reaches the packing state via the registered
// cfg_init strobe. A stalled output holds the result; the next item is taken
// meanwhile and waits in the datapath until the output register is free.
// ----------------------------------------------------------------------------
module glyph_atlas_skyline_packer import gasp_pkg::*; #(
  parameter int MAX_SEGMENTS = 256,
  parameter int COORD_BITS   = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       glyph_width,
  input  logic [11:0]       glyph_height,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              placed,
  output logic [15:0]       page_index,
  output logic [12:0]       x_pos,
  output logic [12:0]       y_pos,
  output logic              opened_page,
  output logic              segment_overflow
);

  logic [12:0] page_width;
  logic [12:0] page_height;
  logic [7:0]  spacing;
  logic        cfg_init;
  logic        cfg_wr;
  logic        reg_known;
  logic [1:0]  reg_sel;
  gasp_cmd_t   cmd;
  gasp_sts_t   sts;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_known = (reg_sel == REG_PAGE_WIDTH) || (reg_sel == REG_PAGE_HEIGHT) ||
                     (reg_sel == REG_SPACING);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width  <= PAGE_WIDTH_RESET;
      page_height <= PAGE_HEIGHT_RESET;
      spacing     <= SPACING_RESET;
      cfg_init    <= 1'b0;
    end else begin
      cfg_init <= cfg_wr && reg_known;
      if (cfg_wr) begin
        case (reg_sel)
          REG_PAGE_WIDTH: begin
            page_width <= pwdata[12:0];
          end
          REG_PAGE_HEIGHT: begin
            page_height <= pwdata[12:0];
          end
          REG_SPACING: begin
            spacing <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PAGE_WIDTH:  prdata = {19'd0, page_width};
      REG_PAGE_HEIGHT: prdata = {19'd0, page_height};
      REG_SPACING:     prdata = {24'd0, spacing};
      default:         prdata = 32'd0;
    endcase
  end

  gasp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gasp_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .page_width       (page_width),
    .page_height      (page_height),
    .spacing          (spacing),
    .cfg_init         (cfg_init),
    .glyph_width      (glyph_width),
    .glyph_height     (glyph_height),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .placed           (placed),
    .page_index       (page_index),
    .x_pos            (x_pos),
    .y_pos            (y_pos),
    .opened_page      (opened_page),
    .segment_overflow (segment_overflow)
  );

endmodule

// ----- rtl/core/gasp_checker.sv -----
// ----------------------------------------------------------------------------
// gasp_checker
// Port-level checks of the packer: result hold under stall, consistency
// of skipped and page-opening results, and the always-ready config port.
// ----------------------------------------------------------------------------
module gasp_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        placed,
  input logic [15:0] page_index,
  input logic [12:0] x_pos,
  input logic [12:0] y_pos,
  input logic        opened_page,
  input logic        segment_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_pos) && $stable(y_pos) &&
      $stable(page_index) && $stable(placed))
    else $error("Result changed while stalled.");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> page_index == 16'd0 && x_pos == 13'd0 && y_pos == 13'd0 &&
      !opened_page && !segment_overflow)
    else $error("Skipped item carries nonzero fields.");

  a_open_placed: assert property (@(posedge clk) disable iff (rst)
    out_valid && opened_page |-> placed && y_pos != 13'd0)
    else $error("Page-opening item is not placed below the top padding.");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("Config port not ready.");

endmodule

bind glyph_atlas_skyline_packer gasp_checker u_gasp_checker (.*);

// ----- verif/gasp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gasp_scoreboard
// Watches the glyph, result and register ports of the skyline packer,
// predicts the placement of every accepted glyph from its own copy of the
// page settings and skyline state, and compares each result field by field
// against the oldest outstanding placement.
// ----------------------------------------------------------------------------
module gasp_scoreboard import gasp_pkg::*; #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [11:0]       glyph_width,
  input  logic [11:0]       glyph_height,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              placed,
  input  logic [15:0]       page_index,
  input  logic [12:0]       x_pos,
  input  logic [12:0]       y_pos,
  input  logic              opened_page,
  input  logic              segment_overflow,
  output int                failures,
  output int                results_seen,
  output int                outstanding
);

  localparam int unsigned COORD_MASK = 32'h1FFF;

  typedef struct packed {
    logic        placed;
    logic [15:0] page_index;
    logic [12:0] x_pos;
    logic [12:0] y_pos;
    logic        opened_page;
    logic        segment_overflow;
  } placement_t;

  placement_t  pending_placements[$];
  placement_t  oldest;

  int unsigned page_w;
  int unsigned page_h;
  int unsigned pad;
  int unsigned cursor;
  int unsigned page_no;
  int unsigned ref_n;
  int unsigned row_n;
  int unsigned bank;
  int unsigned seg_start [2*MAX_SEGMENTS];
  int unsigned seg_end   [2*MAX_SEGMENTS];
  int unsigned seg_y     [2*MAX_SEGMENTS];
  int          err_n;
  int          seen_n;

  function automatic void fresh_skyline();
    int unsigned base;
    base = (bank ^ 1) * MAX_SEGMENTS;
    seg_start[base] = 0;
    seg_end[base]   = page_w & COORD_MASK;
    seg_y[base]     = pad & COORD_MASK;
    ref_n = 1;
    row_n = 0;
  endfunction

  function automatic void restart_packing();
    cursor  = pad & COORD_MASK;
    page_no = 0;
    bank    = 0;
    fresh_skyline();
  endfunction

  function automatic int unsigned skyline_top(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    int unsigned base;
    int unsigned n;
    int unsigned top;
    int unsigned k;
    bit          entered;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    base = (bank ^ 1) * MAX_SEGMENTS;
    n = (ref_n > MAX_SEGMENTS) ? MAX_SEGMENTS : ref_n;
    top = 0;
    entered = 1'b0;
    for (k = 0; k < n; k++) begin
      if (lo >= seg_start[base+k] && lo <= seg_end[base+k]) entered = 1'b1;
      if (entered && seg_y[base+k] > top) top = seg_y[base+k];
      if (hi >= seg_start[base+k] && hi <= seg_end[base+k]) break;
    end
    return top;
  endfunction

  function automatic placement_t place_glyph(logic [11:0] gw, logic [11:0] gh);
    placement_t  r;
    int unsigned w;
    int unsigned h;
    int unsigned left;
    int unsigned right;
    int unsigned top;
    int unsigned bottom;
    int unsigned slot;
    r = '0;
    w = gw;
    h = gh;
    if (w + 2*pad > page_w || h + 2*pad > page_h) return r;
    left  = cursor;
    right = left + w + pad;
    if (right > page_w) begin
      left  = pad;
      right = left + w + pad;
      bank  = bank ^ 1;
      ref_n = row_n;
      row_n = 0;
    end
    top    = skyline_top(left, right);
    bottom = top + h + pad;
    if (bottom > page_h) begin
      if (page_no < 32'hFFFF) page_no++;
      fresh_skyline();
      top    = pad;
      bottom = top + h + pad;
      r.opened_page = 1'b1;
    end
    if (row_n < MAX_SEGMENTS) begin
      slot = bank * MAX_SEGMENTS + row_n;
      seg_start[slot] = left & COORD_MASK;
      seg_end[slot]   = right & COORD_MASK;
      seg_y[slot]     = bottom & COORD_MASK;
      row_n++;
    end else begin
      r.segment_overflow = 1'b1;
    end
    cursor       = right & COORD_MASK;
    r.placed     = 1'b1;
    r.page_index = page_no[15:0];
    r.x_pos      = left[12:0];
    r.y_pos      = top[12:0];
    return r;
  endfunction

  function automatic void apply_write(logic [1:0] index, logic [31:0] value);
    case (index)
      REG_PAGE_WIDTH: begin
        page_w = value & 32'h1FFF;
        restart_packing();
      end
      REG_PAGE_HEIGHT: begin
        page_h = value & 32'h1FFF;
        restart_packing();
      end
      REG_SPACING: begin
        pad = value & 32'hFF;
        if (pad == 0) pad = 1;
        restart_packing();
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_n++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      page_w = PAGE_WIDTH_RESET;
      page_h = PAGE_HEIGHT_RESET;
      pad    = SPACING_RESET;
      restart_packing();
      pending_placements.delete();
      err_n  = 0;
      seen_n = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_n++;
        if (pending_placements.size() == 0) begin
          err_n++;
          $display("%0t ns: result arrived with no glyph outstanding", $time);
        end else begin
          oldest = pending_placements.pop_front();
          check_field("placed", oldest.placed, placed);
          check_field("page_index", oldest.page_index, page_index);
          check_field("x_pos", oldest.x_pos, x_pos);
          check_field("y_pos", oldest.y_pos, y_pos);
          check_field("opened_page", oldest.opened_page, opened_page);
          check_field("segment_overflow", oldest.segment_overflow, segment_overflow);
        end
      end
      if (in_valid && in_ready) begin
        pending_placements.insert(pending_placements.size(),
                                  place_glyph(glyph_width, glyph_height));
      end
      if (psel && penable && pwrite && pready) apply_write(paddr[3:2], pwdata);
    end
    failures     <= err_n;
    results_seen <= seen_n;
    outstanding  <= pending_placements.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the glyph atlas skyline packer: a directed pass over field
// and register extremes, then randomized glyph mixes under varied page
// settings with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import gasp_pkg::*;

  localparam int         MAX_SEGMENTS = 256;
  localparam int         LONG_HOLD    = 400;
  localparam int         PHASE_ITEMS  = 200;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef enum {MIX_SPREAD, MIX_NARROW, MIX_CROWD, MIX_TALL} glyph_mix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [11:0]       glyph_width = '0;
  logic [11:0]       glyph_height = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              placed;
  logic [15:0]       page_index;
  logic [12:0]       x_pos;
  logic [12:0]       y_pos;
  logic              opened_page;
  logic              segment_overflow;

  int                failures;
  int                results_seen;
  int                outstanding;

  int unsigned       cfg_pw = PAGE_WIDTH_RESET;
  int unsigned       cfg_ph = PAGE_HEIGHT_RESET;
  int unsigned       cfg_sp = SPACING_RESET;
  int                items_sent = 0;
  bit                calm = 1'b0;
  bit                hold_now = 1'b0;

  glyph_atlas_skyline_packer #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dut (.*);

  gasp_scoreboard #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_check (.*);

  always #1 clk = ~clk;

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned pw, int unsigned ph, int unsigned sp);
    reg_write(REG_PAGE_WIDTH, pw);
    reg_write(REG_PAGE_HEIGHT, ph);
    reg_write(REG_SPACING, sp);
    cfg_pw = pw & 32'h1FFF;
    cfg_ph = ph & 32'h1FFF;
    cfg_sp = ((sp & 32'hFF) == 0) ? 1 : (sp & 32'hFF);
  endtask

  task automatic send_glyph(logic [11:0] w, logic [11:0] h);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    glyph_width  <= w;
    glyph_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle(int settle);
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic int unsigned room(int unsigned extent);
    int unsigned r;
    r = (extent > 2*cfg_sp) ? extent - 2*cfg_sp : 0;
    return (r > 4095) ? 4095 : r;
  endfunction

  function automatic int unsigned pick_extent();
    case ($urandom_range(0, 3))
      0:       return 4096;
      1:       return $urandom_range(1, 64);
      default: return $urandom_range(65, 4096);
    endcase
  endfunction

  function automatic int unsigned pick_spacing();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic send_random(glyph_mix_t mix);
    int unsigned rw;
    int unsigned rh;
    int unsigned w;
    int unsigned h;
    rw = room(cfg_pw);
    rh = room(cfg_ph);
    if ($urandom_range(0, 15) == 0) begin
      w = $urandom_range(0, 4095);
      h = $urandom_range(0, 4095);
    end else begin
      case (mix)
        MIX_SPREAD: begin
          w = $urandom_range(0, rw);
          h = $urandom_range(0, rh);
        end
        MIX_NARROW: begin
          w = $urandom_range(0, rw / 8);
          h = $urandom_range(0, rh / 4);
        end
        MIX_CROWD: begin
          w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, rw)
                                           : $urandom_range(0, (rw < 3) ? rw : 3);
          h = $urandom_range(0, (rh < 63) ? rh : 63);
        end
        default: begin
          w = $urandom_range(0, rw / 4);
          h = $urandom_range(rh / 2, rh);
        end
      endcase
    end
    send_glyph(w, h);
  endtask

  initial begin
    glyph_mix_t mix;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_glyph(12'd0, 12'd0);
    send_glyph(12'd4095, 12'd4095);
    send_glyph(12'd1022, 12'd0);
    send_glyph(12'd1023, 12'd0);
    send_glyph(12'd0, 12'd1022);
    send_glyph(12'd0, 12'd1023);
    send_glyph(12'd4095, 12'd0);
    send_glyph(12'd0, 12'd4095);
    repeat (6) send_glyph(12'd300, 12'd400);
    wait_idle(8);

    configure(4096, 4096, 0);
    send_glyph(12'd4094, 12'd4094);
    send_glyph(12'd4095, 12'd0);
    send_glyph(12'd0, 12'd4095);
    send_glyph(12'd2047, 12'd2048);
    wait_idle(8);

    configure(1, 1, 255);
    send_glyph(12'd0, 12'd0);
    send_glyph(12'd4095, 12'd4095);
    wait_idle(8);

    configure(600, 600, 255);
    send_glyph(12'd90, 12'd90);
    send_glyph(12'd91, 12'd0);
    wait_idle(8);
    reg_write(REG_UNMAPPED, 32'h0000_0FFF);
    send_glyph(12'd90, 12'd90);
    send_glyph(12'd0, 12'd90);
    wait_idle(8);

    for (int phase = 0; phase < 8; phase++) begin
      mix = glyph_mix_t'(phase % 4);
      case (mix)
        MIX_SPREAD: configure(pick_extent(), pick_extent(), pick_spacing());
        MIX_NARROW: configure($urandom_range(512, 4096), $urandom_range(512, 4096),
                              $urandom_range(1, 4));
        MIX_CROWD:  configure(1024, 4096, 1);
        default:    configure($urandom_range(128, 4096), $urandom_range(16, 512),
                              $urandom_range(1, 8));
      endcase
      if (phase == 7) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 40) hold_now = 1'b1;
        send_random(mix);
      end
      wait_idle(8);
    end

    wait_idle(300);
    if (failures == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gasp_pkg.sv
rtl/core/gasp_ctrl.sv
rtl/core/gasp_dp.sv
rtl/core/glyph_atlas_skyline_packer.sv
rtl/core/gasp_checker.sv
verif/gasp_checker.sv
verif/tb.sv
